// ===== hdl/noc_mesh_mapping_cost_core_macros.svh =====
// Assertion macros shared by the mesh mapping cost core.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef NOC_MESH_MAPPING_COST_CORE_MACROS_SVH
`define NOC_MESH_MAPPING_COST_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Whenever ante holds, cons must hold in the same cycle.
`define NMMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Whenever ante holds, cons must hold in the following cycle.
`define NMMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`else

`define NMMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NMMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/nmmc_pkg.sv =====
`timescale 1ns / 1ps

package nmmc_pkg;

	// Field widths.
	localparam int CMD_W      = 2;
	localparam int CORE_W     = 8;
	localparam int SLOT_IN_W  = 8;
	localparam int BW_W       = 24;
	localparam int COST_W     = 48;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Bandwidth table geometry: one entry per ordered core pair.
	localparam int BW_ADDR_W = 2 * CORE_W;
	localparam int BW_DEPTH  = 1 << BW_ADDR_W;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_WRITE_BW   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_SLOT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EVAL       = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_MESH_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_IN_USE = 1'b1;
	localparam logic [CFG_DATA_W-1:0] MESH_COLUMNS_RST = 9'd12;
	localparam logic [CFG_DATA_W-1:0] TILES_IN_USE_RST = 9'd144;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [CORE_W-1:0]    pair_first_core;
		logic [CORE_W-1:0]    pair_second_core;
		logic [BW_W-1:0]      bandwidth;
		logic [SLOT_IN_W-1:0] slot;
		logic [CORE_W-1:0]    core_at_slot;
	} cmd_t;

	typedef struct packed {
		logic [COST_W-1:0] total_cost;
		logic              saturated;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;
		logic wr_bw;
		logic wr_slot;
		logic eval_start;
		logic row_issue;
		logic pair_issue;
		logic next_row;
		logic load_result;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic tiles_lt2;
		logic pair_last;
		logic row_last;
		logic pipe_busy;
	} ctrl_sts_t;

endpackage

// ===== hdl/nmmc_ctrl.sv =====
`timescale 1ns / 1ps

module nmmc_ctrl
	import nmmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic [CMD_W-1:0] cmd_command,
	output logic             cmd_stall,
	output logic             res_valid,
	input  logic             res_stall,
	output ctrl_cmd_t        ctl,
	input  ctrl_sts_t        sts
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ROW   = 3'd2;
	localparam logic [2:0] ST_PAIR  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       res_valid_q;
	logic       res_free;

	// The result register can take a new value once it is empty or being taken.
	assign res_free = !res_valid_q || !res_stall;

	// Next state and command decode.
	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_command)
						CMD_WRITE_BW: begin
							ctl.wr_bw = 1'b1;
						end
						CMD_WRITE_SLOT: begin
							ctl.wr_slot = 1'b1;
						end
						CMD_EVAL: begin
							ctl.eval_start = 1'b1;
							state_nx = sts.tiles_lt2 ? ST_DONE : ST_ROW;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ROW: begin
				ctl.row_issue = 1'b1;
				state_nx = ST_PAIR;
			end
			ST_PAIR: begin
				ctl.pair_issue = 1'b1;
				if (sts.pair_last) begin
					ctl.next_row = 1'b1;
					state_nx = sts.row_last ? ST_DRAIN : ST_ROW;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					ctl.load_result = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the bandwidth table sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load_result) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

endmodule

// ===== hdl/nmmc_datapath.sv =====
`timescale 1ns / 1ps

module nmmc_datapath
	import nmmc_pkg::*;
#(
	parameter int MAX_TILES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctrl_cmd_t             ctl,
	output ctrl_sts_t             sts,
	output res_t                  res
);

	localparam int CNT_W  = $clog2(MAX_TILES + 1);
	localparam int SLOT_W = $clog2(MAX_TILES);
	localparam int EXT_W  = (CNT_W > CFG_DATA_W) ? CNT_W + 1 : CFG_DATA_W + 1;
	localparam int HOP_W  = CNT_W + 1;
	localparam int PROD_W = BW_W + HOP_W;
	localparam int SUM_W  = COST_W + 1;
	localparam int SEXT_W = SLOT_W + SLOT_IN_W;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] mesh_columns_q;
	logic [CFG_DATA_W-1:0] tiles_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_columns_q <= MESH_COLUMNS_RST;
			tiles_in_use_q <= TILES_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MESH_COLUMNS: mesh_columns_q <= cfg_data;
				REG_TILES_IN_USE: tiles_in_use_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective columns (zero counts as one) and tiles (clamped to the placement depth).
	logic [CFG_DATA_W-1:0] cols_eff;
	logic [EXT_W-1:0]      cols_ext;
	logic [EXT_W-1:0]      tiles_ext;
	logic [CNT_W-1:0]      tiles_eff;
	logic [EXT_W-1:0]      tiles_eff_ext;

	assign cols_eff      = (mesh_columns_q == '0) ? CFG_DATA_W'(1) : mesh_columns_q;
	assign cols_ext      = EXT_W'(cols_eff);
	assign tiles_ext     = EXT_W'(tiles_in_use_q);
	assign tiles_eff     = (tiles_ext > EXT_W'(MAX_TILES)) ? CNT_W'(MAX_TILES)
		: tiles_ext[CNT_W-1:0];
	assign tiles_eff_ext = EXT_W'(tiles_eff);

	// Slot counters with their mesh coordinates, stepped without a divider.
	logic [CNT_W-1:0] m_q, xm_q, ym_q;
	logic [CNT_W-1:0] n_q, xn_q, yn_q;
	logic [CNT_W-1:0] xm_nx, ym_nx, xn_nx, yn_nx;

	always_comb begin
		if (EXT_W'(xm_q) + EXT_W'(1) == cols_ext) begin
			xm_nx = '0;
			ym_nx = ym_q + CNT_W'(1);
		end else begin
			xm_nx = xm_q + CNT_W'(1);
			ym_nx = ym_q;
		end
		if (EXT_W'(xn_q) + EXT_W'(1) == cols_ext) begin
			xn_nx = '0;
			yn_nx = yn_q + CNT_W'(1);
		end else begin
			xn_nx = xn_q + CNT_W'(1);
			yn_nx = yn_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval_start) begin
			m_q  <= '0;
			xm_q <= '0;
			ym_q <= '0;
		end else if (ctl.next_row) begin
			m_q  <= m_q + CNT_W'(1);
			xm_q <= xm_nx;
			ym_q <= ym_nx;
		end
		if (ctl.row_issue) begin
			n_q  <= m_q + CNT_W'(1);
			xn_q <= xm_nx;
			yn_q <= ym_nx;
		end else if (ctl.pair_issue) begin
			n_q  <= n_q + CNT_W'(1);
			xn_q <= xn_nx;
			yn_q <= yn_nx;
		end
	end

	// Manhattan hop count of the pair being issued.
	logic [CNT_W-1:0] dx, dy;
	logic [HOP_W-1:0] hop;

	assign dx  = (xm_q > xn_q) ? (xm_q - xn_q) : (xn_q - xm_q);
	assign dy  = (ym_q > yn_q) ? (ym_q - yn_q) : (yn_q - ym_q);
	assign hop = HOP_W'(dx) + HOP_W'(dy);

	// Placement memory: one write port for loads, one read port for the walk.
	logic [CORE_W-1:0] place_mem [0:MAX_TILES-1];
	logic [CORE_W-1:0] place_rd_q;
	logic [SEXT_W-1:0] slot_ext;
	logic              slot_ok;
	logic [SLOT_W-1:0] place_raddr;

	assign slot_ext    = {{SLOT_W{1'b0}}, cmd.slot};
	assign slot_ok     = (slot_ext < SEXT_W'(MAX_TILES));
	assign place_raddr = ctl.row_issue ? m_q[SLOT_W-1:0] : n_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.wr_slot && slot_ok) begin
			place_mem[slot_ext[SLOT_W-1:0]] <= cmd.core_at_slot;
		end
		place_rd_q <= place_mem[place_raddr];
	end

	// Pipeline tags: stage 1 has the placement read, stage 2 the bandwidth read,
	// stage 3 the product.
	logic             valid_s1, head_s1, valid_s2, valid_s3;
	logic [HOP_W-1:0] hop_s1, hop_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			head_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ctl.row_issue || ctl.pair_issue;
			head_s1  <= ctl.row_issue;
			valid_s2 <= valid_s1 && !head_s1;
			valid_s3 <= valid_s2;
		end
	end

	// A row head captures the core at the lower slot; pairs behind it use it.
	logic [CORE_W-1:0] cm_q;

	always_ff @(posedge clk) begin
		hop_s1 <= hop;
		hop_s2 <= hop_s1;
		if (valid_s1 && head_s1) begin
			cm_q <= place_rd_q;
		end
	end

	// Bandwidth table memory; the clearing sweep shares the write port.
	logic [BW_W-1:0]      bw_mem [0:BW_DEPTH-1];
	logic [BW_W-1:0]      bw_rd_q;
	logic [BW_ADDR_W-1:0] clr_q;
	logic                 bw_we;
	logic [BW_ADDR_W-1:0] bw_waddr;
	logic [BW_W-1:0]      bw_wdata;
	logic [BW_ADDR_W-1:0] bw_raddr;

	assign bw_we    = ctl.clr_en || ctl.wr_bw;
	assign bw_waddr = ctl.clr_en ? clr_q : {cmd.pair_first_core, cmd.pair_second_core};
	assign bw_wdata = ctl.clr_en ? '0 : cmd.bandwidth;
	assign bw_raddr = {cm_q, place_rd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_en) begin
			clr_q <= clr_q + BW_ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (bw_we) begin
			bw_mem[bw_waddr] <= bw_wdata;
		end
		bw_rd_q <= bw_mem[bw_raddr];
	end

	// Multiply bandwidth by hops, then accumulate with saturation.
	logic [PROD_W-1:0] prod_s3;
	logic [COST_W-1:0] acc_q;
	logic              sat_q;
	logic [SUM_W-1:0]  sum;

	assign sum = {1'b0, acc_q} + SUM_W'(prod_s3);

	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(bw_rd_q) * PROD_W'(hop_s2);
		if (ctl.eval_start) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (valid_s3) begin
			if (sum[SUM_W-1]) begin
				acc_q <= COST_MAX;
				sat_q <= 1'b1;
			end else begin
				acc_q <= sum[COST_W-1:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			res.total_cost <= acc_q;
			res.saturated  <= sat_q;
		end
	end

	// Status to the controller.
	assign sts.clr_last  = &clr_q;
	assign sts.tiles_lt2 = (tiles_eff_ext < EXT_W'(2));
	assign sts.pair_last = (EXT_W'(n_q) + EXT_W'(1) == tiles_eff_ext);
	assign sts.row_last  = (EXT_W'(m_q) + EXT_W'(2) >= tiles_eff_ext);
	assign sts.pipe_busy = valid_s1 || valid_s2 || valid_s3;

endmodule

// ===== hdl/noc_mesh_mapping_cost_core.sv =====
// An evaluation over L tiles performs one multiply-accumulate per slot pair
// plus one placement read per row, using the single read port of the
// bandwidth table and of the placement memory.
// After reset a sweep zeroes all 65536 entries of the bandwidth table; no
// command beat is taken during it, configuration writes are.
`timescale 1ns / 1ps

`include "noc_mesh_mapping_cost_core_macros.svh"

module noc_mesh_mapping_cost_core
	import nmmc_pkg::*;
#(
	parameter int MAX_TILES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	// Sequencer for loads, the clearing sweep and the pair walk.
	nmmc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_command (cmd.command),
		.cmd_stall   (cmd_stall),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.ctl         (ctl),
		.sts         (sts)
	);

	// Memories, coordinate counters and the multiply-accumulate pipeline.
	nmmc_datapath #(
		.MAX_TILES (MAX_TILES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.res       (res)
	);

	// No command beat is taken while the table is being cleared.
	`NMMC_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, ctl.clr_en, cmd_stall)
	// A result is loaded only after every pair has left the pipeline.
	`NMMC_ASSERT_IMP(a_drained_at_load, clk, arst_n, ctl.load_result, !sts.pipe_busy)
	// A row head is always followed by at least one pair.
	`NMMC_ASSERT_NEXT(a_row_has_pair, clk, arst_n, ctl.row_issue, ctl.pair_issue)
	// A loaded result is offered in the next cycle.
	`NMMC_ASSERT_NEXT(a_result_offered, clk, arst_n, ctl.load_result, res_valid)

endmodule
